FILE: src/tse_pkg.sv
// shared constants, register indexes and controller/datapath interface types
package tse_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int COEF_WIDTH      = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_SQUARE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_LINEAR   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_CONSTANT = 2'd2;

   localparam logic signed [COEF_WIDTH-1:0] COEF_SQUARE_RESET = 16'sd1;
   localparam logic signed [COEF_WIDTH-1:0] COEF_LINEAR_RESET = -16'sd8;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEP = 8;

   // largest span that goes straight to the final scan
   localparam int SCAN_SPAN = 3;

   typedef struct packed {
      logic load_req;
      logic div_start;
      logic round_upd;
      logic mul_scan;
      logic scan_init;
      logic scan_upd;
      logic load_out;
   } tse_cmd_type;

   typedef struct packed {
      logic span_gt3;
      logic left_lt_right;
      logic div_done;
      logic idx_eq_right;
   } tse_status_type;

endpackage

FILE: src/tse_div3.sv
// iterative unsigned divide by three, DIV_STEP quotient bits per cycle
module tse_div3
   import tse_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int DIV_CYCLES = (WIDTH + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_BITS   = DIV_CYCLES * DIV_STEP;
   localparam int CNT_WIDTH  = $clog2(DIV_CYCLES + 1);

   logic [DIV_BITS-1:0]  work_ff, work_in;
   logic [DIV_BITS-1:0]  quot_ff, quot_in;
   logic [1:0]           rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_STEP-1:0]  qbits;

   // long division, msb first, remainder stays in 0..2
   always_comb begin
      logic [1:0] r;
      logic [2:0] r2;
      r = rem_ff;
      qbits = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
         r2 = {r, work_ff[DIV_BITS-1-j]};
         if (r2 >= 3'd3) begin
            qbits[DIV_STEP-1-j] = 1'b1;
            r2 = r2 - 3'd3;
         end
         r = r2[1:0];
      end
      rem_in = r;
   end

   always_comb begin
      work_in = work_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         work_in = DIV_BITS'(dividend);
         cnt_in  = CNT_WIDTH'(DIV_CYCLES);
      end else if (cnt_ff != '0) begin
         work_in = work_ff << DIV_STEP;
         quot_in = (quot_ff << DIV_STEP) | DIV_BITS'(qbits);
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      quot_ff <= quot_in;
      if (start) begin
         rem_ff <= 2'd0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
      end
   end

   assign done     = (cnt_ff == '0);
   assign quotient = quot_ff[WIDTH-1:0];

endmodule

FILE: src/tse_datapath.sv
// bounds, coefficient registers, shared multiplier and comparison logic
module tse_datapath
   import tse_pkg::*;
#(
   parameter int POS_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_action,
   input  logic [POS_WIDTH-1:0]       req_lower_bound,
   input  logic [POS_WIDTH-1:0]       req_upper_bound,
   output logic [POS_WIDTH-1:0]       rsp_best_position,
   input  tse_cmd_type                cmd,
   output tse_status_type             status
);

   localparam int W = POS_WIDTH;

   logic signed [COEF_WIDTH-1:0] coef_square_ff;
   logic signed [COEF_WIDTH-1:0] coef_linear_ff;

   logic [W-1:0] left_ff, right_ff, best_ff, idx_ff, out_ff;
   logic         want_max_ff;

   logic signed [W:0]    span;
   logic signed [W:0]    sum_sel;
   logic signed [W+16:0] product_in, product_ff;
   logic signed [W+17:0] fsum;
   logic                 s_pos, s_neg, better;
   logic                 div_done;
   logic [W-1:0]         third;

   // coefficient writes; the constant term cancels out of every comparison
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_square_ff <= COEF_SQUARE_RESET;
         coef_linear_ff <= COEF_LINEAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_SQUARE:   coef_square_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_LINEAR:   coef_linear_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_CONSTANT: begin
               // accepted, no effect on the search
            end
            default: begin
            end
         endcase
      end
   end

   assign span = $signed({right_ff[W-1], right_ff}) - $signed({left_ff[W-1], left_ff});

   tse_div3 #(
      .WIDTH(W)
   ) u_div3 (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(span[W-1:0]),
      .done    (div_done),
      .quotient(third)
   );

   // ml + mr equals left + right, so the round product needs no quotient
   assign sum_sel = cmd.mul_scan
      ? $signed({idx_ff[W-1], idx_ff}) + $signed({best_ff[W-1], best_ff})
      : $signed({left_ff[W-1], left_ff}) + $signed({right_ff[W-1], right_ff});

   assign product_in = (W+17)'(coef_square_ff) * (W+17)'(sum_sel);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign fsum   = $signed({product_ff[W+16], product_ff}) + (W+18)'(coef_linear_ff);
   assign s_neg  = fsum[W+17];
   assign s_pos  = !fsum[W+17] && (fsum != '0);
   assign better = want_max_ff ? s_pos : s_neg;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         left_ff     <= req_lower_bound;
         right_ff    <= req_upper_bound;
         want_max_ff <= req_action;
      end else if (cmd.round_upd) begin
         if (better) begin
            left_ff <= left_ff + third;
         end else begin
            right_ff <= right_ff - third;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         best_ff <= left_ff;
         idx_ff  <= left_ff + 1'b1;
      end else if (cmd.scan_upd) begin
         if (better) begin
            best_ff <= idx_ff;
         end
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= best_ff;
      end
   end

   assign rsp_best_position = out_ff;

   assign status.span_gt3      = !span[W] && (span[W-1:0] > W'(SCAN_SPAN));
   assign status.left_lt_right = !span[W] && (span != '0);
   assign status.div_done      = div_done;
   assign status.idx_eq_right  = (idx_ff == right_ff);

endmodule

FILE: src/tse_ctrl.sv
// sequencer for shrinking rounds, final scan and result handoff
module tse_ctrl
   import tse_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   input  tse_status_type status,
   output tse_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ROUND    = 3'd1;
   localparam logic [2:0] ST_DIV      = 3'd2;
   localparam logic [2:0] ST_SCAN_MUL = 3'd3;
   localparam logic [2:0] ST_SCAN_CMP = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.span_gt3) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = status.left_lt_right ? ST_SCAN_MUL : ST_FINISH;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.round_upd = 1'b1;
               state_in      = ST_ROUND;
            end
         end
         ST_SCAN_MUL: begin
            cmd.mul_scan = 1'b1;
            state_in     = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_upd = 1'b1;
            state_in     = status.idx_eq_right ? ST_FINISH : ST_SCAN_MUL;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/ternary_search_extremum.sv
// top level: integer ternary search for the extremum of a configured quadratic
//
// usage
// - req beat: action (0 minimum, 1 maximum) and inclusive signed bounds;
//   taken while the sequencer is idle, one search at a time
// - rsp beat: first position holding the extreme value; an empty interval
//   returns the lower bound
// - csr port: write-only coefficients, written while no search is running;
//   the constant term is accepted but cannot change any comparison
// - each round waits on the divide-by-three unit, which forms span/3 eight
//   quotient bits a cycle; the quadratic sign test runs on the shared
//   multiplier while the divider works
// - a full 32-bit span needs about 53 rounds, then a final scan of up to
//   four points, with a multiply and a compare state for each point after
//   the first, and then a load of the output register
// - the result sits in an output register; a new req beat is taken while
//   it waits, and a finished search holds until the output register frees
// - synchronous reset clears the sequencer and rsp_valid and restores the
//   coefficient reset values
module ternary_search_extremum
   import tse_pkg::*;
#(
   parameter int POS_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [POS_WIDTH-1:0]       req_lower_bound,
   input  logic [POS_WIDTH-1:0]       req_upper_bound,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [POS_WIDTH-1:0]       rsp_best_position,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   tse_cmd_type    cmd;
   tse_status_type status;

   // sequencer: rounds, scan, output handoff
   tse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .status   (status),
      .cmd      (cmd)
   );

   // bounds, multiplier, divider and output register
   tse_datapath #(
      .POS_WIDTH(POS_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_action),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_best_position(rsp_best_position),
      .cmd              (cmd),
      .status           (status)
   );

   // one search at a time: busy right after a req beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req accepted while a search was running");

   // output register only reloaded when empty or being drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("pending rsp beat overwritten");

   // divider only started for a span that still needs a round
   a_div_span: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.span_gt3)
      else $error("divider started on a short span");

   // bounds move only with a finished quotient
   a_upd_quot: assert property (@(posedge clock) disable iff (reset)
      cmd.round_upd |-> (status.div_done && !cmd.div_start))
      else $error("round update before quotient ready");

endmodule
